### sv/tvsg_pkg.sv
// ----------------------------------------------------------------------------
// tvsg_pkg
// shared types, register map and lookup tables of the sound generator
// ----------------------------------------------------------------------------
package tvsg_pkg;

  // item codes
  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_SELECT = 2'd1;
  localparam logic [1:0] MODE_WRITE  = 2'd2;

  // register map
  localparam logic [3:0] REG_NOISE_PERIOD = 4'd6;
  localparam logic [3:0] REG_MIXER        = 4'd7;
  localparam logic [3:0] REG_VOL_A        = 4'd8;
  localparam logic [3:0] REG_ENV_FINE     = 4'd11;
  localparam logic [3:0] REG_ENV_COARSE   = 4'd12;
  localparam logic [3:0] REG_ENV_SHAPE    = 4'd13;

  localparam logic [7:0] SHAPE_IGNORE = 8'hff;
  localparam logic [7:0] ENV_JUMP     = 8'h80;

  // largest raw period fields
  localparam int TONE_RAW_MAX  = 4095;
  localparam int NOISE_RAW_MAX = 31;
  localparam int ENV_RAW_MAX   = 65535;

  localparam int NUM_CH  = 3;
  localparam int VOL_W   = 14;
  localparam int LFSR_W  = 17;
  localparam logic [15:0] MIX_BASE = 16'h8000;

  typedef enum logic [2:0] {
    TBL_DECAY_HOLD,
    TBL_ATTACK_HOLD,
    TBL_DECAY_REPEAT,
    TBL_DECAY_ATTACK,
    TBL_DECAY_HOLD_HIGH,
    TBL_ATTACK_REPEAT,
    TBL_ATTACK_HOLD_HIGH,
    TBL_ATTACK_DECAY
  } env_tbl_t;

  // per-item strobes and settings handed from the register file
  typedef struct packed {
    logic              tick;
    logic              shape_wr;
    logic [NUM_CH-1:0] vol_wr;
    logic [7:0]        data;
    logic [NUM_CH-1:0] tone_off;
    logic [NUM_CH-1:0] noise_off;
    logic [NUM_CH-1:0] env_mode;
  } ctl_t;

  function automatic logic [VOL_W-1:0] level_gain(input logic [3:0] lvl);
    logic [VOL_W-1:0] g;
    unique case (lvl)
      4'd0:  g = 14'd0;
      4'd1:  g = 14'd128;
      4'd2:  g = 14'd207;
      4'd3:  g = 14'd309;
      4'd4:  g = 14'd480;
      4'd5:  g = 14'd809;
      4'd6:  g = 14'd1231;
      4'd7:  g = 14'd2277;
      4'd8:  g = 14'd2586;
      4'd9:  g = 14'd4469;
      4'd10: g = 14'd6170;
      4'd11: g = 14'd7610;
      4'd12: g = 14'd9711;
      4'd13: g = 14'd11817;
      4'd14: g = 14'd14100;
      default: g = 14'd16383;
    endcase
    return g;
  endfunction

  function automatic env_tbl_t shape_table(input logic [3:0] shape);
    env_tbl_t t;
    unique case (shape)
      4'd0, 4'd1, 4'd2, 4'd3, 4'd9:   t = TBL_DECAY_HOLD;
      4'd4, 4'd5, 4'd6, 4'd7, 4'd15:  t = TBL_ATTACK_HOLD;
      4'd8:                           t = TBL_DECAY_REPEAT;
      4'd10:                          t = TBL_DECAY_ATTACK;
      4'd11:                          t = TBL_DECAY_HOLD_HIGH;
      4'd12:                          t = TBL_ATTACK_REPEAT;
      4'd13:                          t = TBL_ATTACK_HOLD_HIGH;
      default:                        t = TBL_ATTACK_DECAY;
    endcase
    return t;
  endfunction

  // envelope step: level in bits 3..0, or a jump with target in bits 6..0
  function automatic logic [7:0] env_entry(input logic [3:0] shape, input logic [5:0] pos);
    env_tbl_t   t;
    logic [7:0] up;
    logic [7:0] down;
    logic [7:0] e;
    t    = shape_table(shape);
    up   = {4'h0, pos[3:0]};
    down = {4'h0, ~pos[3:0]};
    e    = 8'h00;
    if (pos >= 6'd33) begin
      e = ENV_JUMP;
    end else if (pos < 6'd16) begin
      if (t == TBL_DECAY_HOLD || t == TBL_DECAY_REPEAT || t == TBL_DECAY_ATTACK ||
          t == TBL_DECAY_HOLD_HIGH) begin
        e = down;
      end else begin
        e = up;
      end
    end else begin
      unique case (t)
        TBL_DECAY_HOLD: begin
          if (pos == 6'd16) e = ENV_JUMP | 8'd15;
        end
        TBL_ATTACK_HOLD: begin
          if (pos == 6'd17) e = ENV_JUMP | 8'd16;
        end
        TBL_DECAY_REPEAT: begin
          if (pos == 6'd16) e = ENV_JUMP;
        end
        TBL_DECAY_ATTACK: begin
          if (pos < 6'd32) e = up;
          else e = ENV_JUMP;
        end
        TBL_DECAY_HOLD_HIGH: begin
          if (pos == 6'd16) e = 8'd15;
          else if (pos == 6'd17) e = ENV_JUMP | 8'd16;
        end
        TBL_ATTACK_REPEAT: begin
          if (pos == 6'd16) e = ENV_JUMP;
        end
        TBL_ATTACK_HOLD_HIGH: begin
          if (pos == 6'd16) e = ENV_JUMP | 8'd15;
        end
        default: begin
          if (pos < 6'd32) e = down;
          else e = ENV_JUMP;
        end
      endcase
    end
    return e;
  endfunction

endpackage

### sv/tvsg_if.sv
// ----------------------------------------------------------------------------
// tvsg channel interfaces
// valid/ready channels for bus/tick words and for result words
// ----------------------------------------------------------------------------
interface tvsg_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink (input valid, input mode, input data_byte, output ready);
endinterface

interface tvsg_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic [3:0]         envelope_level;

  modport source (output valid, output sample, output envelope_level, input ready);
  modport sink (input valid, input sample, input envelope_level, output ready);
endinterface

### sv/tvsg_regs.sv
// ----------------------------------------------------------------------------
// tvsg_regs
// register file, register select, mixer gates and scaled periods
// ----------------------------------------------------------------------------
module tvsg_regs #(
  parameter int TONE_PRESCALE     = 8,
  parameter int NOISE_PRESCALE    = 8,
  parameter int ENVELOPE_PRESCALE = 16,
  parameter int TONE_W            = 16,
  parameter int NOISE_W           = 8,
  parameter int ENV_W             = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic [1:0]         mode,
  input  logic [7:0]         data,
  output tvsg_pkg::ctl_t     ctl,
  output logic [TONE_W-1:0]  tone_period [tvsg_pkg::NUM_CH],
  output logic [NOISE_W-1:0] noise_period,
  output logic [ENV_W-1:0]   env_period
);

  logic [7:0]         rf_r  [16];
  logic [7:0]         rf_nxt[16];
  logic [7:0]         sel_r;
  logic [5:0]         gates_r;
  logic [TONE_W-1:0]  tone_period_r  [tvsg_pkg::NUM_CH];
  logic [TONE_W-1:0]  tone_period_nxt[tvsg_pkg::NUM_CH];
  logic [NOISE_W-1:0] noise_period_r;
  logic [ENV_W-1:0]   env_period_r;
  logic [3:0]         wr_idx;
  logic               wr;
  logic               rf_wr;
  logic               shape_skip;

  assign wr_idx     = sel_r[3:0];
  assign wr         = step && (mode == tvsg_pkg::MODE_WRITE) && (sel_r[7:4] == 4'h0);
  assign shape_skip = (wr_idx == tvsg_pkg::REG_ENV_SHAPE) && (data == tvsg_pkg::SHAPE_IGNORE);
  assign rf_wr      = wr && !shape_skip;

  always_comb begin
    rf_nxt = rf_r;
    if (rf_wr) begin
      rf_nxt[wr_idx] = data;
    end
  end

  always_comb begin
    for (int i = 0; i < tvsg_pkg::NUM_CH; i++) begin
      tone_period_nxt[i] =
        TONE_W'(32'({rf_nxt[2*i+1][3:0], rf_nxt[2*i]}) * TONE_PRESCALE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        rf_r[i] <= 8'h00;
      end
      sel_r          <= 8'h00;
      gates_r        <= 6'h3f;
      noise_period_r <= '0;
      env_period_r   <= '0;
      for (int i = 0; i < tvsg_pkg::NUM_CH; i++) begin
        tone_period_r[i] <= '0;
      end
    end else begin
      if (step && mode == tvsg_pkg::MODE_SELECT) begin
        sel_r <= data;
      end
      if (rf_wr) begin
        rf_r           <= rf_nxt;
        tone_period_r  <= tone_period_nxt;
        noise_period_r <= NOISE_W'(32'(rf_nxt[tvsg_pkg::REG_NOISE_PERIOD][4:0])
                                   * NOISE_PRESCALE);
        env_period_r   <= ENV_W'(32'({rf_nxt[tvsg_pkg::REG_ENV_COARSE],
                                      rf_nxt[tvsg_pkg::REG_ENV_FINE]})
                                 * ENVELOPE_PRESCALE);
        if (wr_idx == tvsg_pkg::REG_MIXER) begin
          gates_r <= data[5:0];
        end
      end
    end
  end

  always_comb begin
    ctl.tick      = step && (mode == tvsg_pkg::MODE_TICK);
    ctl.shape_wr  = rf_wr && (wr_idx == tvsg_pkg::REG_ENV_SHAPE);
    ctl.data      = data;
    ctl.tone_off  = gates_r[2:0];
    ctl.noise_off = gates_r[5:3];
    for (int i = 0; i < tvsg_pkg::NUM_CH; i++) begin
      ctl.vol_wr[i]   = rf_wr && (wr_idx == tvsg_pkg::REG_VOL_A + 4'(i));
      ctl.env_mode[i] = rf_r[tvsg_pkg::REG_VOL_A + 4'(i)][4];
    end
  end

  assign tone_period  = tone_period_r;
  assign noise_period = noise_period_r;
  assign env_period   = env_period_r;

endmodule

### sv/tvsg_tone.sv
// ----------------------------------------------------------------------------
// tvsg_tone
// one tone channel: period counter and square phase
// ----------------------------------------------------------------------------
module tvsg_tone #(
  parameter int TONE_W = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              tick,
  input  logic [TONE_W-1:0] period,
  output logic              phase_nxt
);

  logic [TONE_W-1:0] cnt_r;
  logic [TONE_W-1:0] cnt_nxt;
  logic [TONE_W:0]   cnt_inc;
  logic              phase_r;

  assign cnt_inc = {1'b0, cnt_r} + 1'b1;

  always_comb begin
    priority if (period == '0 && !phase_r) begin
      cnt_nxt   = cnt_r;
      phase_nxt = 1'b1;
    end else if (cnt_inc >= {1'b0, period}) begin
      cnt_nxt   = '0;
      phase_nxt = ~phase_r;
    end else begin
      cnt_nxt   = cnt_inc[TONE_W-1:0];
      phase_nxt = phase_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      phase_r <= 1'b0;
    end else if (tick) begin
      cnt_r   <= cnt_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

### sv/tvsg_env.sv
// ----------------------------------------------------------------------------
// tvsg_env
// envelope generator: period counter, shape and step position
// ----------------------------------------------------------------------------
module tvsg_env #(
  parameter int ENV_W = 20
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tvsg_pkg::ctl_t             ctl,
  input  logic [ENV_W-1:0]           period,
  output logic                       reload,
  output logic [tvsg_pkg::VOL_W-1:0] gain_nxt,
  output logic [3:0]                 env_level
);

  logic [ENV_W-1:0] cnt_r;
  logic [ENV_W:0]   cnt_inc;
  logic             fire;
  logic [3:0]       shape_r;
  logic [3:0]       shape_nxt;
  logic [5:0]       pos_r;
  logic [5:0]       pos_nxt;
  logic [5:0]       pos_inc;
  logic [7:0]       step_entry;
  logic [7:0]       cur_entry;
  logic [7:0]       nxt_entry;

  assign cnt_inc    = {1'b0, cnt_r} + 1'b1;
  assign fire       = ctl.tick && (cnt_inc >= {1'b0, period});
  assign pos_inc    = pos_r + 6'd1;
  assign step_entry = tvsg_pkg::env_entry(shape_r, pos_inc);

  always_comb begin
    shape_nxt = shape_r;
    pos_nxt   = pos_r;
    priority if (ctl.shape_wr) begin
      shape_nxt = ctl.data[3:0];
      pos_nxt   = 6'd0;
    end else if (fire) begin
      pos_nxt = step_entry[7] ? step_entry[5:0] : pos_inc;
    end else begin
      pos_nxt = pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      shape_r <= 4'h0;
      pos_r   <= 6'd0;
    end else begin
      if (ctl.tick) begin
        cnt_r <= fire ? '0 : cnt_inc[ENV_W-1:0];
      end
      shape_r <= shape_nxt;
      pos_r   <= pos_nxt;
    end
  end

  assign nxt_entry = tvsg_pkg::env_entry(shape_nxt, pos_nxt);
  assign cur_entry = tvsg_pkg::env_entry(shape_r, pos_r);
  assign gain_nxt  = tvsg_pkg::level_gain(nxt_entry[3:0]);
  assign reload    = fire || ctl.shape_wr;
  assign env_level = cur_entry[3:0];

endmodule

### sv/tvsg_mix.sv
// ----------------------------------------------------------------------------
// tvsg_mix
// noise source, channel volumes and output mixer
// ----------------------------------------------------------------------------
module tvsg_mix #(
  parameter int NOISE_W = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tvsg_pkg::ctl_t              ctl,
  input  logic [NOISE_W-1:0]          noise_period,
  input  logic                        reload,
  input  logic [tvsg_pkg::VOL_W-1:0]  gain_nxt,
  input  logic [tvsg_pkg::NUM_CH-1:0] phase_nxt,
  output logic [15:0]                 sample
);

  logic [NOISE_W-1:0]                cnt_r;
  logic [NOISE_W:0]                  cnt_inc;
  logic                              fire;
  logic [tvsg_pkg::LFSR_W-1:0]       lfsr_r;
  logic                              fb;
  logic                              noise_r;
  logic                              noise_nxt;
  logic [tvsg_pkg::VOL_W-1:0]        vol_r  [tvsg_pkg::NUM_CH];
  logic [tvsg_pkg::VOL_W-1:0]        vol_nxt[tvsg_pkg::NUM_CH];
  logic [tvsg_pkg::NUM_CH-1:0]       gate;
  logic [15:0]                       mix_r;
  logic [15:0]                       mix_nxt;

  assign cnt_inc   = {1'b0, cnt_r} + 1'b1;
  assign fire      = cnt_inc >= {1'b0, noise_period};
  assign fb        = lfsr_r[0] ^ lfsr_r[2];
  assign noise_nxt = fire ? (noise_r ^ fb) : noise_r;

  always_comb begin
    for (int i = 0; i < tvsg_pkg::NUM_CH; i++) begin
      priority if (ctl.vol_wr[i]) begin
        vol_nxt[i] = ctl.data[4] ? gain_nxt : tvsg_pkg::level_gain(ctl.data[3:0]);
      end else if (reload && ctl.env_mode[i]) begin
        vol_nxt[i] = gain_nxt;
      end else begin
        vol_nxt[i] = vol_r[i];
      end
    end
  end

  // tone and noise gates, then sum of the open channels
  always_comb begin
    mix_nxt = tvsg_pkg::MIX_BASE;
    for (int i = 0; i < tvsg_pkg::NUM_CH; i++) begin
      gate[i] = (ctl.tone_off[i] | phase_nxt[i]) & (ctl.noise_off[i] | noise_nxt);
      if (gate[i]) begin
        mix_nxt = mix_nxt + 16'(vol_nxt[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      lfsr_r  <= tvsg_pkg::LFSR_W'(1);
      noise_r <= 1'b0;
      mix_r   <= tvsg_pkg::MIX_BASE;
      for (int i = 0; i < tvsg_pkg::NUM_CH; i++) begin
        vol_r[i] <= '0;
      end
    end else begin
      vol_r <= vol_nxt;
      if (ctl.tick) begin
        mix_r   <= mix_nxt;
        noise_r <= noise_nxt;
        if (fire) begin
          cnt_r  <= '0;
          lfsr_r <= {fb, lfsr_r[tvsg_pkg::LFSR_W-1:1]};
        end else begin
          cnt_r <= cnt_inc[NOISE_W-1:0];
        end
      end
    end
  end

  assign sample = mix_r;

endmodule

### sv/three_voice_sound_generator_unit.sv
// ----------------------------------------------------------------------------
// three_voice_sound_generator_unit
// three tone channels, noise and envelope, mixed to a 16-bit sample
// ----------------------------------------------------------------------------
// in_ch carries one word per chip event: mode 0 is a clock tick, mode 1
// latches a register number, mode 2 writes the latched register with
// data_byte. Every word accepted yields exactly one word on out_ch: the
// mixed sample and the envelope step as they stand after that word.
// A word goes through the input register and the state update into the
// result register, from where it is offered on out_ch. One word a cycle
// is sustained while out_ch does not stall, set by the single state update
// path from input register to result register.
// Reset (synchronous, active low) clears the register file, puts all mixer
// gates in the off state, seeds the noise shift register with one and
// sets the sample to -32768. While out_ch is stalled the result holds,
// one more word is taken into the input register and in_ch.ready then
// drops until the result is taken.
// ----------------------------------------------------------------------------
module three_voice_sound_generator_unit #(
  parameter int TONE_PRESCALE     = 8,
  parameter int NOISE_PRESCALE    = 8,
  parameter int ENVELOPE_PRESCALE = 16
) (
  input logic        clk,
  input logic        rst_n,
  tvsg_in_if.sink    in_ch,
  tvsg_out_if.source out_ch
);

  localparam int TONE_W  = $clog2(tvsg_pkg::TONE_RAW_MAX * TONE_PRESCALE + 1);
  localparam int NOISE_W = $clog2(tvsg_pkg::NOISE_RAW_MAX * NOISE_PRESCALE + 1);
  localparam int ENV_W   = $clog2(tvsg_pkg::ENV_RAW_MAX * ENVELOPE_PRESCALE + 1);

  logic                        item_valid_r;
  logic [1:0]                  item_mode_r;
  logic [7:0]                  item_data_r;
  logic                        out_valid_r;
  logic                        advance;
  logic                        step;
  logic                        in_ready;
  tvsg_pkg::ctl_t              ctl;
  logic [TONE_W-1:0]           tone_period [tvsg_pkg::NUM_CH];
  logic [NOISE_W-1:0]          noise_period;
  logic [ENV_W-1:0]            env_period;
  logic                        reload;
  logic [tvsg_pkg::VOL_W-1:0]  gain_nxt;
  logic [3:0]                  env_level;
  logic [tvsg_pkg::NUM_CH-1:0] phase_nxt;
  logic [15:0]                 sample;

  assign advance  = !out_valid_r || out_ch.ready;
  assign step     = item_valid_r && advance;
  assign in_ready = !item_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_ready) begin
        item_valid_r <= in_ch.valid;
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      item_mode_r <= in_ch.mode;
      item_data_r <= in_ch.data_byte;
    end
  end

  tvsg_regs #(
    .TONE_PRESCALE     (TONE_PRESCALE),
    .NOISE_PRESCALE    (NOISE_PRESCALE),
    .ENVELOPE_PRESCALE (ENVELOPE_PRESCALE),
    .TONE_W            (TONE_W),
    .NOISE_W           (NOISE_W),
    .ENV_W             (ENV_W)
  ) u_regs (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .mode         (item_mode_r),
    .data         (item_data_r),
    .ctl          (ctl),
    .tone_period  (tone_period),
    .noise_period (noise_period),
    .env_period   (env_period)
  );

  for (genvar g = 0; g < tvsg_pkg::NUM_CH; g++) begin : g_tone
    tvsg_tone #(
      .TONE_W (TONE_W)
    ) u_tone (
      .clk       (clk),
      .rst_n     (rst_n),
      .tick      (ctl.tick),
      .period    (tone_period[g]),
      .phase_nxt (phase_nxt[g])
    );
  end

  tvsg_env #(
    .ENV_W (ENV_W)
  ) u_env (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .period    (env_period),
    .reload    (reload),
    .gain_nxt  (gain_nxt),
    .env_level (env_level)
  );

  tvsg_mix #(
    .NOISE_W (NOISE_W)
  ) u_mix (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .noise_period (noise_period),
    .reload       (reload),
    .gain_nxt     (gain_nxt),
    .phase_nxt    (phase_nxt),
    .sample       (sample)
  );

  assign in_ch.ready           = in_ready;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.sample         = $signed(sample);
  assign out_ch.envelope_level = env_level;

  // sample only moves on a processed word
  a_sample_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !step) |=> $stable(out_ch.sample))
    else $error("sample changed without a processed word");

  // envelope step only moves on a processed word
  a_level_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !step) |=> $stable(out_ch.envelope_level))
    else $error("envelope level changed without a processed word");

  // stalled result with a held input word blocks further input
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready && item_valid_r) |-> !in_ch.ready)
    else $error("input taken while both stages are full");

  // three full-scale channels from the base never reach the clamp
  a_mix_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.sample[15] || (out_ch.sample <= 16'sd16381))
    else $error("mixed sample above reachable range");

endmodule

### test/tb_three_voice_sound_generator_unit.sv
// ----------------------------------------------------------------------------
// tb_three_voice_sound_generator_unit
// self-checking bench for the three-voice sound generator: a short table of
// directed bus and tick words, then random words, mostly ticks mixed with
// register traffic, every result word compared with a word-level model of the
// tone, noise, envelope and mixer state under random stalls on both channels
// ----------------------------------------------------------------------------
module tb_three_voice_sound_generator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TONE_DIV     = 8;
  localparam int NOISE_DIV    = 8;
  localparam int ENV_DIV      = 16;
  localparam int REG_COUNT    = 16;
  localparam int MIX_FLOOR    = -32768;
  localparam int MIX_CEIL     = 32767;
  localparam int RESET_CYCLES = 9;
  localparam int SCRIPT_LEN   = 25;
  localparam int WORD_TOTAL   = 1875;
  localparam int HOLD_AT      = 600;
  localparam int HOLD_CYCLES  = 300;
  localparam int CALM_AT      = 1500;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 200000;

  localparam logic [1:0] MODE_UNUSED       = 2'd3;
  localparam logic [7:0] REG_TONE_A_FINE   = 8'd0;
  localparam logic [7:0] REG_TONE_A_COARSE = 8'd1;
  localparam logic [7:0] REG_VOL_B         = 8'd9;
  localparam logic [7:0] REG_PORT_A        = 8'd14;
  localparam logic [7:0] REG_OUT_OF_RANGE  = 8'hff;

  typedef struct packed {
    logic signed [15:0] sample;
    logic [3:0]         level;
  } sound_word_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  data;
    logic        known;
    sound_word_t result;
  } script_row_t;

  logic clk;
  logic rst_n;

  tvsg_in_if  in_ch ();
  tvsg_out_if out_ch ();

  three_voice_sound_generator_unit #(
    .TONE_PRESCALE    (TONE_DIV),
    .NOISE_PRESCALE   (NOISE_DIV),
    .ENVELOPE_PRESCALE(ENV_DIV)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // model state
  logic [7:0]  regfile [REG_COUNT];
  logic [7:0]  reg_sel;
  int          tone_cnt [tvsg_pkg::NUM_CH];
  logic        tone_ph [tvsg_pkg::NUM_CH];
  logic        tone_off [tvsg_pkg::NUM_CH];
  logic        noise_off [tvsg_pkg::NUM_CH];
  int          ch_vol [tvsg_pkg::NUM_CH];
  int          noise_cnt;
  logic [16:0] lfsr;
  logic        noise_lvl;
  int          env_cnt;
  logic [3:0]  env_shape;
  logic [7:0]  env_pos;
  int          mix;

  sound_word_t pending_samples [$];
  int          errors = 0;
  int          sent = 0;
  int          cycles = 0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  bit          calm = 1'b0;

  function automatic int gain_of(input logic [3:0] lvl);
    int g;
    case (lvl)
      4'd0:    g = 0;
      4'd1:    g = 513 / 4;
      4'd2:    g = 828 / 4;
      4'd3:    g = 1239 / 4;
      4'd4:    g = 1923 / 4;
      4'd5:    g = 3238 / 4;
      4'd6:    g = 4926 / 4;
      4'd7:    g = 9110 / 4;
      4'd8:    g = 10344 / 4;
      4'd9:    g = 17876 / 4;
      4'd10:   g = 24682 / 4;
      4'd11:   g = 30442 / 4;
      4'd12:   g = 38844 / 4;
      4'd13:   g = 47270 / 4;
      4'd14:   g = 56402 / 4;
      default: g = 65535 / 4;
    endcase
    return g;
  endfunction

  function automatic tvsg_pkg::env_tbl_t table_for(input logic [3:0] shape);
    tvsg_pkg::env_tbl_t t;
    case (shape)
      4'd8:    t = tvsg_pkg::TBL_DECAY_REPEAT;
      4'd10:   t = tvsg_pkg::TBL_DECAY_ATTACK;
      4'd11:   t = tvsg_pkg::TBL_DECAY_HOLD_HIGH;
      4'd12:   t = tvsg_pkg::TBL_ATTACK_REPEAT;
      4'd13:   t = tvsg_pkg::TBL_ATTACK_HOLD_HIGH;
      4'd14:   t = tvsg_pkg::TBL_ATTACK_DECAY;
      4'd15:   t = tvsg_pkg::TBL_ATTACK_HOLD;
      default: t = shape[2] ? tvsg_pkg::TBL_ATTACK_HOLD : tvsg_pkg::TBL_DECAY_HOLD;
    endcase
    return t;
  endfunction

  // level in bits 3..0, or a jump flag with the target position below it
  function automatic logic [7:0] envelope_entry(input logic [7:0] pos);
    tvsg_pkg::env_tbl_t t;
    logic [7:0]         rise;
    logic [7:0]         fall;
    logic [7:0]         e;
    logic               falls_first;
    t           = table_for(env_shape);
    rise        = {4'h0, pos[3:0]};
    fall        = {4'h0, ~pos[3:0]};
    falls_first = (t == tvsg_pkg::TBL_DECAY_HOLD) || (t == tvsg_pkg::TBL_DECAY_REPEAT) ||
                  (t == tvsg_pkg::TBL_DECAY_ATTACK) ||
                  (t == tvsg_pkg::TBL_DECAY_HOLD_HIGH);
    e = 8'h00;
    if (pos >= 8'd33) begin
      e = tvsg_pkg::ENV_JUMP;
    end else if (pos < 8'd16) begin
      e = falls_first ? fall : rise;
    end else begin
      case (t)
        tvsg_pkg::TBL_DECAY_HOLD, tvsg_pkg::TBL_ATTACK_HOLD_HIGH: begin
          if (pos == 8'd16) e = tvsg_pkg::ENV_JUMP | 8'd15;
        end
        tvsg_pkg::TBL_ATTACK_HOLD: begin
          if (pos == 8'd17) e = tvsg_pkg::ENV_JUMP | 8'd16;
        end
        tvsg_pkg::TBL_DECAY_REPEAT, tvsg_pkg::TBL_ATTACK_REPEAT: begin
          if (pos == 8'd16) e = tvsg_pkg::ENV_JUMP;
        end
        tvsg_pkg::TBL_DECAY_ATTACK: begin
          e = (pos < 8'd32) ? rise : tvsg_pkg::ENV_JUMP;
        end
        tvsg_pkg::TBL_DECAY_HOLD_HIGH: begin
          if (pos == 8'd16) e = 8'd15;
          else if (pos == 8'd17) e = tvsg_pkg::ENV_JUMP | 8'd16;
        end
        default: begin
          e = (pos < 8'd32) ? fall : tvsg_pkg::ENV_JUMP;
        end
      endcase
    end
    return e;
  endfunction

  function automatic int envelope_gain();
    logic [7:0] e;
    e = envelope_entry(env_pos);
    return gain_of(e[3:0]);
  endfunction

  function automatic void write_register(input logic [7:0] r, input logic [7:0] v);
    int ch;
    if (r == tvsg_pkg::REG_ENV_SHAPE) begin
      if (v != tvsg_pkg::SHAPE_IGNORE) begin
        regfile[tvsg_pkg::REG_ENV_SHAPE] = v;
        env_shape = v[3:0];
        env_pos = 8'h00;
        for (ch = 0; ch < tvsg_pkg::NUM_CH; ch++) begin
          if (regfile[tvsg_pkg::REG_VOL_A + ch][4]) ch_vol[ch] = envelope_gain();
        end
      end
    end else begin
      regfile[r[3:0]] = v;
      if (r == tvsg_pkg::REG_MIXER) begin
        for (ch = 0; ch < tvsg_pkg::NUM_CH; ch++) begin
          tone_off[ch]  = v[ch];
          noise_off[ch] = v[ch + 3];
        end
      end else if (r >= tvsg_pkg::REG_VOL_A &&
                   r < tvsg_pkg::REG_VOL_A + tvsg_pkg::NUM_CH) begin
        ch = r - tvsg_pkg::REG_VOL_A;
        ch_vol[ch] = v[4] ? envelope_gain() : gain_of(v[3:0]);
      end
    end
  endfunction

  function automatic void chip_tick();
    int         per;
    int         sum;
    int         ch;
    logic       fb;
    logic [7:0] e;
    per = int'(regfile[tvsg_pkg::REG_NOISE_PERIOD][4:0]) * NOISE_DIV;
    noise_cnt++;
    if (noise_cnt >= per) begin
      fb        = lfsr[0] ^ lfsr[2];
      lfsr      = {fb, lfsr[16:1]};
      noise_lvl = noise_lvl ^ fb;
      noise_cnt = 0;
    end
    for (ch = 0; ch < tvsg_pkg::NUM_CH; ch++) begin
      per = int'({regfile[2 * ch + 1][3:0], regfile[2 * ch]}) * TONE_DIV;
      if (per == 0 && !tone_ph[ch]) begin
        tone_ph[ch] = 1'b1;
      end else begin
        tone_cnt[ch]++;
        if (tone_cnt[ch] >= per) begin
          tone_cnt[ch] = 0;
          tone_ph[ch]  = ~tone_ph[ch];
        end
      end
    end
    per = int'({regfile[tvsg_pkg::REG_ENV_COARSE], regfile[tvsg_pkg::REG_ENV_FINE]}) *
          ENV_DIV;
    env_cnt++;
    if (env_cnt >= per) begin
      env_cnt = 0;
      env_pos++;
      e = envelope_entry(env_pos);
      if (e[7]) env_pos = {1'b0, e[6:0]};
      for (ch = 0; ch < tvsg_pkg::NUM_CH; ch++) begin
        if (regfile[tvsg_pkg::REG_VOL_A + ch][4]) ch_vol[ch] = envelope_gain();
      end
    end
    sum = MIX_FLOOR;
    for (ch = 0; ch < tvsg_pkg::NUM_CH; ch++) begin
      if ((tone_off[ch] | tone_ph[ch]) & (noise_off[ch] | noise_lvl)) sum += ch_vol[ch];
    end
    if (sum > MIX_CEIL) sum = MIX_CEIL;
    mix = sum;
  endfunction

  function automatic sound_word_t advance_chip(input logic [1:0] m, input logic [7:0] d);
    sound_word_t w;
    logic [7:0]  e;
    case (m)
      tvsg_pkg::MODE_TICK:   chip_tick();
      tvsg_pkg::MODE_SELECT: reg_sel = d;
      tvsg_pkg::MODE_WRITE: begin
        if (reg_sel < REG_COUNT) write_register(reg_sel, d);
      end
      default: ;
    endcase
    e        = envelope_entry(env_pos);
    w.sample = mix[15:0];
    w.level  = e[3:0];
    return w;
  endfunction

  task automatic report_mismatch(input string what, input logic signed [31:0] got,
                                 input logic signed [31:0] want);
    $display("%0t ns: %s got %0d want %0d", $time, what, got, want);
    errors++;
  endtask

  task automatic send_word(input logic [1:0] m, input logic [7:0] d, input logic known,
                           input sound_word_t known_word);
    sound_word_t w;
    int          gap;
    gap = 0;
    if (!calm && !(hold_req && !hold_done) && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 11);
    end
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= m;
    in_ch.data_byte <= d;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    w = advance_chip(m, d);
    pending_samples.push_back(known ? known_word : w);
    sent++;
    if (sent == HOLD_AT) hold_req = 1'b1;
    if (sent == CALM_AT) calm = 1'b1;
  endtask

  // mostly ticks, otherwise well-formed select/write pairs or stray words
  task automatic random_item();
    int         pick;
    logic [7:0] r;
    logic [7:0] v;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      send_word(tvsg_pkg::MODE_TICK, 8'($urandom), 1'b0, '0);
    end else if (pick < 94) begin
      r = 8'($urandom_range(0, REG_COUNT - 1));
      v = 8'($urandom);
      if (r < tvsg_pkg::REG_NOISE_PERIOD && $urandom_range(0, 7) != 0) begin
        if (r[0]) v[3:0] = 4'h0;
        else v = 8'($urandom_range(0, 15));
      end else if (r == tvsg_pkg::REG_ENV_FINE && $urandom_range(0, 7) != 0) begin
        v = 8'($urandom_range(0, 8));
      end else if (r == tvsg_pkg::REG_ENV_COARSE && $urandom_range(0, 15) != 0) begin
        v = 8'h00;
      end else if (r == tvsg_pkg::REG_ENV_SHAPE && $urandom_range(0, 9) == 0) begin
        v = tvsg_pkg::SHAPE_IGNORE;
      end
      send_word(tvsg_pkg::MODE_SELECT, r, 1'b0, '0);
      send_word(tvsg_pkg::MODE_WRITE, v, 1'b0, '0);
    end else begin
      case ($urandom_range(0, 2))
        0:       send_word(tvsg_pkg::MODE_SELECT, 8'($urandom), 1'b0, '0);
        1:       send_word(tvsg_pkg::MODE_WRITE, 8'($urandom), 1'b0, '0);
        default: send_word(MODE_UNUSED, 8'($urandom), 1'b0, '0);
      endcase
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 11);
        out_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    sound_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_samples.size() == 0) begin
        report_mismatch("unexpected word, sample", out_ch.sample, 0);
      end else begin
        want = pending_samples.pop_front();
        if (out_ch.sample !== want.sample) begin
          report_mismatch("sample", out_ch.sample, want.sample);
        end
        if (out_ch.envelope_level !== want.level) begin
          report_mismatch("envelope level", out_ch.envelope_level, want.level);
        end
      end
    end
  end

  initial begin
    script_row_t script [SCRIPT_LEN];
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.mode      <= tvsg_pkg::MODE_TICK;
    in_ch.data_byte <= 8'h00;

    foreach (regfile[i]) regfile[i] = 8'h00;
    foreach (tone_cnt[i]) begin
      tone_cnt[i]  = 0;
      tone_ph[i]   = 1'b0;
      tone_off[i]  = 1'b1;
      noise_off[i] = 1'b1;
      ch_vol[i]    = 0;
    end
    reg_sel   = 8'h00;
    noise_cnt = 0;
    lfsr      = 17'd1;
    noise_lvl = 1'b0;
    env_cnt   = 0;
    env_shape = 4'h0;
    env_pos   = 8'h00;
    mix       = MIX_FLOOR;

    script[0]  = '{tvsg_pkg::MODE_SELECT, REG_TONE_A_FINE, 1'b1, '{tvsg_pkg::MIX_BASE, 4'd15}};
    script[1]  = '{MODE_UNUSED, 8'hff, 1'b1, '{tvsg_pkg::MIX_BASE, 4'd15}};
    script[2]  = '{tvsg_pkg::MODE_SELECT, tvsg_pkg::REG_VOL_A, 1'b1,
                   '{tvsg_pkg::MIX_BASE, 4'd15}};
    script[3]  = '{tvsg_pkg::MODE_WRITE, 8'h0f, 1'b1, '{tvsg_pkg::MIX_BASE, 4'd15}};
    script[4]  = '{tvsg_pkg::MODE_TICK, 8'h00, 1'b1, '{-16'sd16385, 4'd14}};
    script[5]  = '{tvsg_pkg::MODE_SELECT, REG_OUT_OF_RANGE, 1'b1, '{-16'sd16385, 4'd14}};
    script[6]  = '{tvsg_pkg::MODE_WRITE, 8'h55, 1'b1, '{-16'sd16385, 4'd14}};
    script[7]  = '{tvsg_pkg::MODE_SELECT, tvsg_pkg::REG_ENV_SHAPE, 1'b0, '0};
    script[8]  = '{tvsg_pkg::MODE_WRITE, tvsg_pkg::SHAPE_IGNORE, 1'b0, '0};
    script[9]  = '{tvsg_pkg::MODE_WRITE, 8'h0e, 1'b0, '0};
    script[10] = '{tvsg_pkg::MODE_SELECT, tvsg_pkg::REG_MIXER, 1'b0, '0};
    script[11] = '{tvsg_pkg::MODE_WRITE, 8'h00, 1'b0, '0};
    script[12] = '{tvsg_pkg::MODE_TICK, 8'hff, 1'b0, '0};
    script[13] = '{tvsg_pkg::MODE_SELECT, REG_VOL_B, 1'b0, '0};
    script[14] = '{tvsg_pkg::MODE_WRITE, 8'h1f, 1'b0, '0};
    script[15] = '{tvsg_pkg::MODE_SELECT, REG_PORT_A, 1'b0, '0};
    script[16] = '{tvsg_pkg::MODE_WRITE, 8'ha5, 1'b0, '0};
    script[17] = '{tvsg_pkg::MODE_SELECT, REG_TONE_A_COARSE, 1'b0, '0};
    script[18] = '{tvsg_pkg::MODE_WRITE, 8'hff, 1'b0, '0};
    script[19] = '{tvsg_pkg::MODE_SELECT, tvsg_pkg::REG_NOISE_PERIOD, 1'b0, '0};
    script[20] = '{tvsg_pkg::MODE_WRITE, 8'hff, 1'b0, '0};
    script[21] = '{tvsg_pkg::MODE_TICK, 8'h5a, 1'b0, '0};
    script[22] = '{tvsg_pkg::MODE_SELECT, tvsg_pkg::REG_ENV_COARSE, 1'b0, '0};
    script[23] = '{tvsg_pkg::MODE_WRITE, 8'hff, 1'b0, '0};
    script[24] = '{tvsg_pkg::MODE_TICK, 8'h00, 1'b0, '0};

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      send_word(script[i].mode, script[i].data, script[i].known, script[i].result);
    end
    while (sent < WORD_TOTAL) random_item();
    @(negedge clk);
    in_ch.valid <= 1'b0;

    while (pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### filelist.f
sv/tvsg_pkg.sv
sv/tvsg_if.sv
sv/tvsg_regs.sv
sv/tvsg_tone.sv
sv/tvsg_env.sv
sv/tvsg_mix.sv
sv/three_voice_sound_generator_unit.sv
test/tb_three_voice_sound_generator_unit.sv
